// ===== hdl/scr_pkg.sv =====
// Package for the SPI slave command responder.
// Holds the protocol character codes and the motor command encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

  localparam logic [7:0] ChStart  = 8'h73;
  localparam logic [7:0] ChDHead  = 8'h48;
  localparam logic [7:0] ChLinAcc = 8'h58;
  localparam logic [7:0] ChYAcc   = 8'h79;
  localparam logic [7:0] ChHead   = 8'h54;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChThree  = 8'h33;
  localparam logic [7:0] ChFour   = 8'h34;
  localparam logic [7:0] ChIrL    = 8'h6C;
  localparam logic [7:0] ChIrR    = 8'h72;
  localparam logic [7:0] ChCmd    = 8'h43;
  localparam logic [7:0] ChFwd    = 8'h66;
  localparam logic [7:0] ChBack   = 8'h42;
  localparam logic [7:0] ChHalt   = 8'h68;
  localparam logic [7:0] ChRotL   = 8'h4C;
  localparam logic [7:0] ChRotR   = 8'h52;
  localparam logic [7:0] ChEnd    = 8'h65;
  localparam logic [7:0] ChDummy  = 8'h5F;
  localparam logic [7:0] ChAck    = 8'h21;
  localparam logic [7:0] ChErr    = 8'h62;
  localparam logic [7:0] ChEndAck = 8'h64;

  typedef enum logic [2:0] {
    MotNone  = 3'd0,
    MotFwd   = 3'd1,
    MotBack  = 3'd2,
    MotHalt  = 3'd3,
    MotLeft  = 3'd4,
    MotRight = 3'd5
  } motor_cmd_e;

endpackage

`default_nettype wire

// ===== hdl/scr_if.sv =====
// Valid/ready channel interfaces for the SPI slave command responder.
// One interface for the received byte with sensor snapshots, one for the reply.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] lacc_word;
  logic [31:0] y_accel_word;
  logic [31:0] heading_word;
  logic [7:0]  calib_status;
  logic [7:0]  ir_left;
  logic [7:0]  ir_right;
  logic [2:0]  motor_state_now;

  modport source (
    output valid, rx_byte, lacc_word, y_accel_word, heading_word,
           calib_status, ir_left, ir_right, motor_state_now,
    input  ready
  );
  modport sink (
    input  valid, rx_byte, lacc_word, y_accel_word, heading_word,
           calib_status, ir_left, ir_right, motor_state_now,
    output ready
  );
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic [2:0]  motor_command;
  logic        motor_change;
  logic [31:0] heading_target;

  modport source (
    output valid, tx_byte, motor_command, motor_change, heading_target,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, motor_command, motor_change, heading_target,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/spi_slave_command_responder.sv =====
// SPI slave command responder: decodes one received byte per beat and forms the reply.
// Depends on scr_pkg and the channel interfaces in scr_if.sv.
// Each accepted input beat goes through the input register, then the result register.
// Throughput: one beat per cycle while the reply side is not stalled, set by the single decode
// pass between the two registers; the message state updates as each beat is decoded.
// Reset (asynchronous, active low) empties both stages and clears all message state.
`timescale 1ns / 1ps
`default_nettype none

module spi_slave_command_responder
  import scr_pkg::*;
#(
  parameter int MSG_BUFFER_BYTES = 10
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  scr_in_if.sink    in_i,
  scr_out_if.source out_o
);

  localparam int PosW = $clog2(MSG_BUFFER_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(MSG_BUFFER_BYTES - 1);

  // Input stage
  logic        s1_vld_q;
  logic [7:0]  rx_q;
  logic [31:0] lin_q, yac_q, hdg_q;
  logic [7:0]  calib_q, irl_q, irr_q;
  logic [2:0]  now_q;
  logic        s1_adv;

  // Message state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      lead_q, lead_d;
  logic [7:0]      req_q, req_d;
  logic [1:0]      hidx_q, hidx_d;
  logic [31:0]     htgt_q, htgt_d;

  // Result stage
  logic        out_vld_q;
  logic [7:0]  tx_q, tx_d;
  motor_cmd_e  cmd_q, cmd_d;
  logic        chg_q, chg_d;

  logic [PosW-1:0] pos_a, pos_n;
  logic            vstart, vcmd, vlin, vy, vhd, vdh;
  logic [1:0]      didx;
  logic [4:0]      bshift;

  assign s1_adv     = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || s1_adv;

  always_comb begin
    pos_a = (rx_q == ChStart) ? '0 : pos_q;
    if (pos_a >= PosLast) begin
      pos_a = '0;
    end
    lead_d = lead_q;
    req_d  = req_q;
    if (pos_a == '0) begin
      lead_d = rx_q;
    end else if (pos_a == PosW'(1)) begin
      req_d = rx_q;
    end
    pos_n  = pos_a + PosW'(1);
    vstart = (lead_d == ChStart);
    vcmd   = 1'b0;
    vlin   = 1'b0;
    vy     = 1'b0;
    vhd    = 1'b0;
    vdh    = 1'b0;
    if (pos_n > PosW'(1)) begin
      vcmd = vstart && (req_d == ChCmd);
      vlin = vstart && (req_d == ChLinAcc);
      vy   = vstart && (req_d == ChYAcc);
      vhd  = vstart && (req_d == ChHead);
      vdh  = vstart && (req_d == ChDHead) && (pos_n < PosW'(7)) && (pos_n > PosW'(2));
    end

    didx   = 2'(rx_q - ChOne);
    bshift = {didx, 3'b000};
    hidx_d = hidx_q;
    htgt_d = htgt_q;
    cmd_d  = MotNone;
    tx_d   = ChErr;

    if (vdh) begin
      htgt_d = (htgt_q & ~(32'hFF << {hidx_q, 3'b000})) | ({24'd0, rx_q} << {hidx_q, 3'b000});
      hidx_d = hidx_q + 2'd1;
      tx_d   = rx_q;
    end else begin
      unique case (rx_q) inside
        ChStart: tx_d = ChAck;
        ChLinAcc, ChYAcc, ChHead: begin
          if (vstart && pos_n == PosW'(2)) tx_d = calib_q;
        end
        ChDHead, ChCmd: begin
          if (vstart && pos_n == PosW'(2)) tx_d = ChAck;
        end
        ChOne, ChTwo, ChThree, ChFour: begin
          if (pos_n == PosW'(didx) + PosW'(3)) begin
            if (vlin) tx_d = 8'(lin_q >> bshift);
            else if (vy) tx_d = 8'(yac_q >> bshift);
            else if (vhd) tx_d = 8'(hdg_q >> bshift);
          end
        end
        ChIrL: begin
          if (vstart && pos_n == PosW'(2)) tx_d = irl_q;
        end
        ChIrR: begin
          if (vstart && pos_n == PosW'(3)) tx_d = irr_q;
        end
        ChFwd, ChBack, ChHalt, ChRotL, ChRotR: begin
          if (vcmd && pos_n == PosW'(3)) begin
            tx_d = rx_q;
            if (rx_q == ChFwd) cmd_d = MotFwd;
            else if (rx_q == ChBack) cmd_d = MotBack;
            else if (rx_q == ChHalt) cmd_d = MotHalt;
            else if (rx_q == ChRotL) cmd_d = MotLeft;
            else cmd_d = MotRight;
          end
        end
        ChEnd: begin
          if (vstart && (pos_n == PosW'(7) || pos_n == PosW'(4))) tx_d = ChEndAck;
        end
        ChDummy: tx_d = ChDummy;
        default: tx_d = ChErr;
      endcase
    end

    pos_d = (tx_d == ChErr || tx_d == ChDummy) ? '0 : pos_n;
    chg_d = (cmd_d != MotNone) && (cmd_d != motor_cmd_e'(now_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
      lead_q    <= '0;
      req_q     <= '0;
      hidx_q    <= '0;
      htgt_q    <= '0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q;
      end
      if (s1_vld_q && s1_adv) begin
        pos_q  <= pos_d;
        lead_q <= lead_d;
        req_q  <= req_d;
        hidx_q <= hidx_d;
        htgt_q <= htgt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      rx_q    <= in_i.rx_byte;
      lin_q   <= in_i.lacc_word;
      yac_q   <= in_i.y_accel_word;
      hdg_q   <= in_i.heading_word;
      calib_q <= in_i.calib_status;
      irl_q   <= in_i.ir_left;
      irr_q   <= in_i.ir_right;
      now_q   <= in_i.motor_state_now;
    end
    if (s1_vld_q && s1_adv) begin
      tx_q  <= tx_d;
      cmd_q <= cmd_d;
      chg_q <= chg_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.tx_byte        = tx_q;
  assign out_o.motor_command  = cmd_q;
  assign out_o.motor_change   = chg_q;
  assign out_o.heading_target = htgt_q;

  // The message position always stays inside the buffer.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("message position beyond buffer");

  // A motor change is only ever flagged together with a decoded command.
  a_chg_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && chg_q |-> cmd_q != MotNone)
    else $error("motor change without a command");

  // A decoded command is always echoed as the reply byte.
  a_cmd_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && cmd_q != MotNone |->
      (tx_q == ChFwd || tx_q == ChBack || tx_q == ChHalt || tx_q == ChRotL || tx_q == ChRotR))
    else $error("command not echoed");

  // The heading register only moves when a beat is decoded.
  a_htgt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && s1_adv) |=> $stable(htgt_q))
    else $error("heading target changed without a beat");

  // Error and dummy replies always restart the message.
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s1_adv && (tx_d == ChErr || tx_d == ChDummy) |=> pos_q == '0)
    else $error("position not cleared after error or dummy reply");

endmodule

`default_nettype wire

// ===== bench/tb_spi_slave_command_responder.sv =====
// Self-checking testbench for the SPI slave command responder.
// Drives received bytes with sensor snapshots; checks replies against a script or predictor.
// Depends on scr_pkg, the channel interfaces in scr_if.sv and the responder itself.
`timescale 1ns / 1ps

module tb_spi_slave_command_responder;
  import scr_pkg::*;

  localparam int MsgBufferBytes = 10;
  localparam int TotalBeats     = 1900;
  localparam int StallLimit     = 2000;
  localparam int MaxReported    = 10;
  localparam logic [2:0] StateBogus = 3'd7;

  typedef enum logic [1:0] {
    FillZero,
    FillOnes,
    FillRandom,
    FillErrByte
  } fill_e;

  typedef struct packed {
    logic [7:0]  rx;
    logic [31:0] lacc;
    logic [31:0] y_accel;
    logic [31:0] heading;
    logic [7:0]  calib;
    logic [7:0]  ir_l;
    logic [7:0]  ir_r;
    logic [2:0]  motor_now;
  } spi_beat_t;

  typedef struct packed {
    logic [7:0]  tx;
    motor_cmd_e  cmd;
    logic        change;
    logic [31:0] head_target;
  } reply_t;

  typedef struct packed {
    logic [7:0] rx;
    fill_e      fill;
    logic [2:0] now;
    logic       typed;
    reply_t     want;
  } script_row_t;

  localparam reply_t NoWant = '0;

  script_row_t script [28] = '{
    '{8'h00,    FillZero,    MotNone,    1'b1, '{ChErr,    MotNone,  1'b0, 32'h0000_0000}},
    '{8'hFF,    FillOnes,    StateBogus, 1'b1, '{ChErr,    MotNone,  1'b0, 32'h0000_0000}},
    '{ChDummy,  FillZero,    MotNone,    1'b1, '{ChDummy,  MotNone,  1'b0, 32'h0000_0000}},
    '{ChStart,  FillZero,    MotFwd,     1'b1, '{ChAck,    MotNone,  1'b0, 32'h0000_0000}},
    '{ChDHead,  FillZero,    MotFwd,     1'b1, '{ChAck,    MotNone,  1'b0, 32'h0000_0000}},
    '{8'hFF,    FillZero,    MotBack,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'h0000_00FF}},
    '{8'hFF,    FillZero,    MotBack,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'h0000_FFFF}},
    '{8'hFF,    FillZero,    MotBack,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'h00FF_FFFF}},
    '{8'hFF,    FillZero,    MotBack,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChEnd,    FillZero,    MotHalt,    1'b1, '{ChEndAck, MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChStart,  FillOnes,    MotLeft,    1'b1, '{ChAck,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChLinAcc, FillOnes,    MotLeft,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChOne,    FillOnes,    MotRight,   1'b1, '{8'hFF,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChTwo,    FillRandom,  MotRight,   1'b0, NoWant},
    '{ChEnd,    FillRandom,  MotNone,    1'b0, NoWant},
    '{ChStart,  FillRandom,  MotNone,    1'b0, NoWant},
    '{ChCmd,    FillRandom,  MotNone,    1'b0, NoWant},
    '{ChRotR,   FillRandom,  StateBogus, 1'b1, '{ChRotR,   MotRight, 1'b1, 32'hFFFF_FFFF}},
    '{ChEnd,    FillRandom,  MotNone,    1'b0, NoWant},
    '{ChStart,  FillZero,    MotNone,    1'b0, NoWant},
    '{ChCmd,    FillOnes,    MotNone,    1'b0, NoWant},
    '{ChIrR,    FillOnes,    MotNone,    1'b1, '{8'hFF,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChEnd,    FillRandom,  MotNone,    1'b0, NoWant},
    '{ChStart,  FillErrByte, MotNone,    1'b0, NoWant},
    '{ChIrL,    FillErrByte, MotNone,    1'b1, '{ChErr,    MotNone,  1'b0, 32'hFFFF_FFFF}},
    '{ChStart,  FillRandom,  MotFwd,     1'b0, NoWant},
    '{ChCmd,    FillRandom,  MotFwd,     1'b0, NoWant},
    '{ChFwd,    FillRandom,  MotFwd,     1'b1, '{ChFwd,    MotFwd,   1'b0, 32'hFFFF_FFFF}}
  };

  logic [7:0] proto_chars [22] = '{
    ChStart, ChDHead, ChLinAcc, ChYAcc, ChHead, ChOne, ChTwo, ChThree, ChFour, ChIrL, ChIrR,
    ChCmd, ChFwd, ChBack, ChHalt, ChRotL, ChRotR, ChEnd, ChDummy, ChAck, ChErr, ChEndAck
  };
  logic [7:0] motor_chars [5]  = '{ChFwd, ChBack, ChHalt, ChRotL, ChRotR};
  logic [7:0] sensor_chars [3] = '{ChLinAcc, ChYAcc, ChHead};

  logic clk_i;
  logic rst_ni;

  scr_in_if  in_bus ();
  scr_out_if out_bus ();

  spi_slave_command_responder #(
    .MSG_BUFFER_BYTES(MsgBufferBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Predictor state of the message decoder.
  logic [3:0]  msg_pos;
  logic [7:0]  lead_byte;
  logic [7:0]  request_byte;
  logic [1:0]  head_idx;
  logic [31:0] head_target;

  reply_t    pending_replies [$];
  logic      drv_typed;
  reply_t    drv_want;
  logic      in_calm;
  int        beats_sent;
  int        faults;
  int        idle_cycles;
  spi_beat_t seen;
  reply_t    exp_reply;
  reply_t    got;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic reply_t predict_reply(input spi_beat_t b);
    logic [3:0] pos;
    logic [1:0] digit;
    logic [7:0] tx;
    motor_cmd_e cmd;
    logic       started;
    logic       ask_cmd;
    logic       ask_lin;
    logic       ask_y;
    logic       ask_head;
    logic       writing_head;
    reply_t     r;
    pos = msg_pos;
    if (b.rx == ChStart) pos = '0;
    if (pos >= MsgBufferBytes - 1) pos = '0;
    if (pos == 4'd0) lead_byte = b.rx;
    else if (pos == 4'd1) request_byte = b.rx;
    pos = pos + 4'd1;

    started      = (lead_byte == ChStart);
    ask_cmd      = (pos > 4'd1) && started && (request_byte == ChCmd);
    ask_lin      = (pos > 4'd1) && started && (request_byte == ChLinAcc);
    ask_y        = (pos > 4'd1) && started && (request_byte == ChYAcc);
    ask_head     = (pos > 4'd1) && started && (request_byte == ChHead);
    writing_head = started && (request_byte == ChDHead) && (pos > 4'd2) && (pos < 4'd7);

    cmd = MotNone;
    if (writing_head) begin
      head_target[8*head_idx +: 8] = b.rx;
      head_idx = head_idx + 2'd1;
      tx = b.rx;
    end else begin
      tx = ChErr;
      case (b.rx)
        ChStart: tx = ChAck;
        ChLinAcc, ChYAcc, ChHead: if (started && pos == 4'd2) tx = b.calib;
        ChDHead, ChCmd: if (started && pos == 4'd2) tx = ChAck;
        ChOne, ChTwo, ChThree, ChFour: begin
          digit = 2'(b.rx - ChOne);
          if (pos == digit + 4'd3) begin
            if (ask_lin) tx = b.lacc[8*digit +: 8];
            else if (ask_y) tx = b.y_accel[8*digit +: 8];
            else if (ask_head) tx = b.heading[8*digit +: 8];
          end
        end
        ChIrL: if (started && pos == 4'd2) tx = b.ir_l;
        ChIrR: if (started && pos == 4'd3) tx = b.ir_r;
        ChFwd, ChBack, ChHalt, ChRotL, ChRotR: if (ask_cmd && pos == 4'd3) begin
          tx = b.rx;
          case (b.rx)
            ChFwd:   cmd = MotFwd;
            ChBack:  cmd = MotBack;
            ChHalt:  cmd = MotHalt;
            ChRotL:  cmd = MotLeft;
            default: cmd = MotRight;
          endcase
        end
        ChEnd: if (started && (pos == 4'd7 || pos == 4'd4)) tx = ChEndAck;
        ChDummy: tx = ChDummy;
        default: ;
      endcase
    end

    // The position follows the reply value, whatever produced it.
    if (tx == ChErr || tx == ChDummy) pos = '0;
    msg_pos = pos;

    r.tx          = tx;
    r.cmd         = cmd;
    r.change      = (cmd != MotNone) && (cmd != b.motor_now);
    r.head_target = head_target;
    return r;
  endfunction

  function automatic spi_beat_t random_snapshot(input logic [7:0] rx);
    spi_beat_t b;
    b.rx        = rx;
    b.lacc      = $urandom;
    b.y_accel   = $urandom;
    b.heading   = $urandom;
    b.calib     = 8'($urandom_range(0, 255));
    b.ir_l      = 8'($urandom_range(0, 255));
    b.ir_r      = 8'($urandom_range(0, 255));
    b.motor_now = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 15))
      0: b.calib = ChErr;
      1: b.calib = ChDummy;
      2: b.ir_l = ChErr;
      3: b.ir_r = ChDummy;
      4: b.lacc = {4{ChErr}};
      5: b.y_accel = {4{ChDummy}};
      6: b.heading = {4{ChErr}};
      default: ;
    endcase
    return b;
  endfunction

  task automatic push_beat(input spi_beat_t b, input logic typed, input reply_t want);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.rx_byte         <= b.rx;
    in_bus.lacc_word       <= b.lacc;
    in_bus.y_accel_word    <= b.y_accel;
    in_bus.heading_word    <= b.heading;
    in_bus.calib_status    <= b.calib;
    in_bus.ir_left         <= b.ir_l;
    in_bus.ir_right        <= b.ir_r;
    in_bus.motor_state_now <= b.motor_now;
    drv_typed = typed;
    drv_want  = want;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic report_fault(input string what, input reply_t want, input reply_t have);
    faults++;
    if (faults <= MaxReported) begin
      $display("%s: expected tx %h cmd %0d chg %b head %h, got tx %h cmd %0d chg %b head %h",
               what, want.tx, want.cmd, want.change, want.head_target,
               have.tx, have.cmd, have.change, have.head_target);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      seen.rx        = in_bus.rx_byte;
      seen.lacc      = in_bus.lacc_word;
      seen.y_accel   = in_bus.y_accel_word;
      seen.heading   = in_bus.heading_word;
      seen.calib     = in_bus.calib_status;
      seen.ir_l      = in_bus.ir_left;
      seen.ir_r      = in_bus.ir_right;
      seen.motor_now = in_bus.motor_state_now;
      exp_reply = predict_reply(seen);
      if (drv_typed) exp_reply = drv_want;
      pending_replies.push_back(exp_reply);
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.tx          = out_bus.tx_byte;
      got.cmd         = motor_cmd_e'(out_bus.motor_command);
      got.change      = out_bus.motor_change;
      got.head_target = out_bus.heading_target;
      if (pending_replies.size() == 0) begin
        report_fault("unexpected reply beat", NoWant, got);
      end else begin
        exp_reply = pending_replies.pop_front();
        if (got.tx !== exp_reply.tx || got.cmd !== exp_reply.cmd ||
            got.change !== exp_reply.change || got.head_target !== exp_reply.head_target) begin
          report_fault("reply mismatch", exp_reply, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("No beat moved for %0d cycles.", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : reply_sink
    int stall;
    int calm_left;
    out_bus.ready = 1'b0;
    calm_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (calm_left != 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(10, 60);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    spi_beat_t  beat;
    logic [7:0] msg [$];
    int         kind;
    int         len;

    in_bus.valid           = 1'b0;
    in_bus.rx_byte         = '0;
    in_bus.lacc_word       = '0;
    in_bus.y_accel_word    = '0;
    in_bus.heading_word    = '0;
    in_bus.calib_status    = '0;
    in_bus.ir_left         = '0;
    in_bus.ir_right        = '0;
    in_bus.motor_state_now = '0;
    drv_typed    = 1'b0;
    drv_want     = NoWant;
    in_calm      = 1'b0;
    beats_sent   = 0;
    faults       = 0;
    idle_cycles  = 0;
    msg_pos      = '0;
    lead_byte    = '0;
    request_byte = '0;
    head_idx     = '0;
    head_target  = '0;

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      beat = random_snapshot(script[i].rx);
      case (script[i].fill)
        FillZero: {beat.lacc, beat.y_accel, beat.heading,
                   beat.calib, beat.ir_l, beat.ir_r} = '0;
        FillOnes: {beat.lacc, beat.y_accel, beat.heading,
                   beat.calib, beat.ir_l, beat.ir_r} = '1;
        FillErrByte: {beat.lacc, beat.y_accel, beat.heading,
                      beat.calib, beat.ir_l, beat.ir_r} = {15{ChErr}};
        default: ;
      endcase
      beat.motor_now = script[i].now;
      push_beat(beat, script[i].typed, script[i].want);
    end

    // Mostly well-formed messages with random content, with some noise and broken ones.
    while (beats_sent < TotalBeats) begin
      msg.delete();
      kind = $urandom_range(0, 9);
      if (kind != 8) msg.push_back(ChStart);
      case (kind)
        0, 1, 2: begin
          msg.push_back(sensor_chars[$urandom_range(0, 2)]);
          for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 5) == 0) msg.push_back(8'(ChOne + $urandom_range(0, 3)));
            else msg.push_back(8'(ChOne + k));
          end
          if ($urandom_range(0, 3) != 0) msg.push_back(ChEnd);
        end
        3, 4: begin
          msg.push_back(ChDHead);
          for (int k = 0; k < 4; k++) msg.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) != 0) msg.push_back(ChEnd);
        end
        5, 6: begin
          msg.push_back(ChCmd);
          msg.push_back(motor_chars[$urandom_range(0, 4)]);
          if ($urandom_range(0, 3) != 0) msg.push_back(ChEnd);
        end
        7: begin
          if ($urandom_range(0, 1) == 0) begin
            msg.push_back(ChIrL);
          end else begin
            msg.push_back(proto_chars[$urandom_range(0, 21)]);
            msg.push_back(ChIrR);
          end
          if ($urandom_range(0, 1) == 0) msg.push_back(ChEnd);
        end
        8: begin
          len = $urandom_range(1, 4);
          repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          len = $urandom_range(1, 9);
          repeat (len) msg.push_back(proto_chars[$urandom_range(0, 21)]);
        end
      endcase
      if ($urandom_range(0, 7) == 0) in_calm = !in_calm;
      foreach (msg[k]) push_beat(random_snapshot(msg[k]), 1'b0, NoWant);
    end

    in_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (pending_replies.size() != 0) begin
      $display("%0d reply beats never arrived.", pending_replies.size());
    end
    if (faults == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
